// ----- rtl/tilt_est_pkg.sv -----
// Constants, register map and arctangent table for the tilt estimator.
// Used by tilt_estimator_with_balance_qualifier_top; depends on nothing.
package tilt_est_pkg;

	// Build defaults
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int QUALIFY_TICKS_DEF = 5;
	localparam int ATAN_LEN          = 24;
	localparam int ATAN_IDX_W        = 5;

	// Register map, word index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_GYRO_OFFSET     = 2'd0,
		REG_UPDATE_PERIOD   = 2'd1,
		REG_START_THRESHOLD = 2'd2,
		REG_STOP_THRESHOLD  = 2'd3
	} reg_idx_t;

	localparam logic signed [15:0] GYRO_OFFSET_RST     = 16'sd0;
	localparam logic [7:0]         UPDATE_PERIOD_RST   = 8'd10;
	localparam logic [17:0]        START_THRESHOLD_RST = 18'd20000;
	localparam logic [17:0]        STOP_THRESHOLD_RST  = 18'd45000;

	// Division by 29 as multiply by ceil(2^20/29), exact for |n| < 2^17
	localparam logic [15:0] RECIP_MUL   = 16'd36158;
	localparam int          RECIP_SHIFT = 20;

	localparam logic signed [12:0] USED_LIMIT   = 13'sd50;
	localparam logic signed [12:0] FREEZE_LIMIT = 13'sd2;

	// 180 degrees in 1/256 millidegree
	localparam logic signed [31:0] HALF_TURN = 32'sd46080177;

	// atan(2^-i) in 1/256 millidegree
	function automatic logic signed [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:    v = 32'sd11520044;
			5'd1:    v = 32'sd6800679;
			5'd2:    v = 32'sd3593292;
			5'd3:    v = 32'sd1824011;
			5'd4:    v = 32'sd915545;
			5'd5:    v = 32'sd458219;
			5'd6:    v = 32'sd229165;
			5'd7:    v = 32'sd114590;
			5'd8:    v = 32'sd57296;
			5'd9:    v = 32'sd28648;
			5'd10:   v = 32'sd14324;
			5'd11:   v = 32'sd7162;
			5'd12:   v = 32'sd3581;
			5'd13:   v = 32'sd1790;
			5'd14:   v = 32'sd895;
			5'd15:   v = 32'sd448;
			5'd16:   v = 32'sd224;
			5'd17:   v = 32'sd112;
			5'd18:   v = 32'sd56;
			5'd19:   v = 32'sd28;
			5'd20:   v = 32'sd14;
			5'd21:   v = 32'sd7;
			5'd22:   v = 32'sd3;
			5'd23:   v = 32'sd2;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	// Sequencer states
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_RATE   = 7'b0000010,
		ST_PRED   = 7'b0000100,
		ST_CORDIC = 7'b0001000,
		ST_ACC    = 7'b0010000,
		ST_BLEND  = 7'b0100000,
		ST_QUAL   = 7'b1000000
	} state_t;

endpackage

// ----- rtl/tilt_estimator_with_balance_qualifier_top.sv -----
// Complementary-filter tilt estimator with balance-mode qualifier.
// Depends on tilt_est_pkg (register map, constants, arctangent table).
//
// Channel   | Dir | Signals                    | Contents
// ----------+-----+----------------------------+-----------------------------------------
// s_axis    | in  | tvalid tready tdata[47:0]  | one tick: gyro_y, accel_x, accel_z
// m_axis    | out | tvalid tready tdata[47:0]  | tilt_angle, tilt_rate, balancing, accel_used
// APB       | in  | psel penable pwrite paddr  | four config registers at 0x0/0x4/0x8/0xC
//
// A tick passes the rate, prediction, CORDIC, accumulate, blend and qualify steps in order,
// one CORDIC rotation per cycle, and the next tick is taken once the last has left them.
// s_axis_tready is high only while the sequencer is idle.
// A tick taken while the previous result still waits holds in its last step until the
// result register is empty.
// arst_n clears the estimate, balance mode, qualifier count and config to defaults.
module tilt_estimator_with_balance_qualifier_top #(
	parameter int CORDIC_STEPS  = tilt_est_pkg::CORDIC_STEPS_DEF,
	parameter int QUALIFY_TICKS = tilt_est_pkg::QUALIFY_TICKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // gyro_y[15:0], accel_x[31:16], accel_z[47:32]

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // tilt_angle[31:0], tilt_rate[44:32],
	                                   // balancing[45], accel_used[46], zero[47]

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int QCNT_W = (QUALIFY_TICKS > 0) ? $clog2(QUALIFY_TICKS + 1) : 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
	localparam logic [QCNT_W-1:0] QUAL_MAX  = QCNT_W'(QUALIFY_TICKS);

	// Configuration
	logic signed [15:0] gyro_offset_q;
	logic [7:0]         update_period_q;
	logic [17:0]        start_threshold_q;
	logic [17:0]        stop_threshold_q;
	logic               cfg_wr;
	tilt_est_pkg::reg_idx_t cfg_idx;

	// Estimator state
	tilt_est_pkg::state_t state_q;
	logic [31:0]        angle_q;
	logic               balance_q;
	logic [QCNT_W-1:0]  qcnt_q;

	// Per-tick working registers
	logic signed [16:0] diff_q;
	logic signed [12:0] rate_q;
	logic [31:0]        pred_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [STEP_W-1:0]  step_q;
	logic               zero_vec_q;

	// Result register
	logic               m_valid_q;
	logic [47:0]        m_data_q;

	// Combinational
	logic signed [15:0] in_gyro, in_ax, in_az;
	logic signed [31:0] ax_ext, az_ext;
	logic [16:0]        diff_mag;
	logic [32:0]        recip_prod;
	logic [12:0]        quot;
	logic signed [21:0] rate_x_period;
	logic signed [31:0] sx, sy, atan_v;
	logic signed [31:0] z_biased;
	logic [31:0]        blend_sum;
	logic               used, freeze;
	logic [31:0]        angle_mag;
	logic               qualifies;
	logic               bal_next;
	logic [QCNT_W-1:0]  qcnt_next;
	logic               out_free;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = tilt_est_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			tilt_est_pkg::REG_GYRO_OFFSET:     prdata = 32'(gyro_offset_q);
			tilt_est_pkg::REG_UPDATE_PERIOD:   prdata = {24'd0, update_period_q};
			tilt_est_pkg::REG_START_THRESHOLD: prdata = {14'd0, start_threshold_q};
			tilt_est_pkg::REG_STOP_THRESHOLD:  prdata = {14'd0, stop_threshold_q};
			default:                           prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_offset_q     <= tilt_est_pkg::GYRO_OFFSET_RST;
			update_period_q   <= tilt_est_pkg::UPDATE_PERIOD_RST;
			start_threshold_q <= tilt_est_pkg::START_THRESHOLD_RST;
			stop_threshold_q  <= tilt_est_pkg::STOP_THRESHOLD_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				tilt_est_pkg::REG_GYRO_OFFSET:     gyro_offset_q     <= pwdata[15:0];
				tilt_est_pkg::REG_UPDATE_PERIOD:   update_period_q   <= pwdata[7:0];
				tilt_est_pkg::REG_START_THRESHOLD: start_threshold_q <= pwdata[17:0];
				tilt_est_pkg::REG_STOP_THRESHOLD:  stop_threshold_q  <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	// Input unpack and CORDIC preload values (scaled by 4096)
	assign in_gyro = s_axis_tdata[15:0];
	assign in_ax   = s_axis_tdata[31:16];
	assign in_az   = s_axis_tdata[47:32];
	assign ax_ext  = {{4{in_ax[15]}}, in_ax, 12'd0};
	assign az_ext  = {{4{in_az[15]}}, in_az, 12'd0};

	// Rate: |diff| * recip >> 20, sign restored
	assign diff_mag   = diff_q[16] ? 17'(-diff_q) : 17'(diff_q);
	assign recip_prod = 33'(diff_mag) * 33'(tilt_est_pkg::RECIP_MUL);
	assign quot       = recip_prod[tilt_est_pkg::RECIP_SHIFT +: 13];

	assign rate_x_period = 22'(rate_q) * 22'($signed({1'b0, update_period_q}));

	// One CORDIC rotation
	assign sx     = cx_q >>> step_q;
	assign sy     = cy_q >>> step_q;
	assign atan_v = tilt_est_pkg::atan_lut(tilt_est_pkg::ATAN_IDX_W'(step_q));

	// Truncate toward zero on the /256
	assign z_biased = cz_q + (cz_q[31] ? 32'sd255 : 32'sd0);

	assign used   = (rate_q > -tilt_est_pkg::USED_LIMIT) && (rate_q < tilt_est_pkg::USED_LIMIT);
	assign freeze = (rate_q > -tilt_est_pkg::FREEZE_LIMIT)
	             && (rate_q < tilt_est_pkg::FREEZE_LIMIT);

	// 252*pred + 4*acc, wrapping
	assign blend_sum = (pred_q << 8) - (pred_q << 2) + (32'(acc_q) << 2);

	// Balance qualifier
	assign angle_mag = angle_q[31] ? (32'd0 - angle_q) : angle_q;
	assign qualifies = balance_q ? (angle_mag > {14'd0, stop_threshold_q})
	                             : (angle_mag < {14'd0, start_threshold_q});

	always_comb begin
		bal_next  = balance_q;
		qcnt_next = '0;
		if (qualifies) begin
			if (qcnt_q == QUAL_MAX) begin
				bal_next = ~balance_q;
			end else begin
				qcnt_next = qcnt_q + 1'b1;
			end
		end
	end

	assign out_free      = ~m_valid_q | m_axis_tready;
	assign s_axis_tready = (state_q == tilt_est_pkg::ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Load on a finished tick, drop once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == tilt_est_pkg::ST_QUAL) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tilt_est_pkg::ST_IDLE;
			angle_q   <= 32'd0;
			balance_q <= 1'b0;
			qcnt_q    <= '0;
			step_q    <= '0;
		end else begin
			case (state_q)
				tilt_est_pkg::ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= tilt_est_pkg::ST_RATE;
					end
				end
				tilt_est_pkg::ST_RATE:  state_q <= tilt_est_pkg::ST_PRED;
				tilt_est_pkg::ST_PRED: begin
					step_q  <= '0;
					state_q <= tilt_est_pkg::ST_CORDIC;
				end
				tilt_est_pkg::ST_CORDIC: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= tilt_est_pkg::ST_ACC;
					end
				end
				tilt_est_pkg::ST_ACC:   state_q <= tilt_est_pkg::ST_BLEND;
				tilt_est_pkg::ST_BLEND: begin
					if (!balance_q && freeze) begin
						angle_q <= 32'(acc_q);
					end else if (used) begin
						angle_q <= 32'($signed(blend_sum) >>> 8);
					end else begin
						angle_q <= pred_q;
					end
					state_q <= tilt_est_pkg::ST_QUAL;
				end
				tilt_est_pkg::ST_QUAL: begin
					// hold until the result register can take this tick
					if (out_free) begin
						balance_q <= bal_next;
						qcnt_q    <= qcnt_next;
						state_q   <= tilt_est_pkg::ST_IDLE;
					end
				end
				default: state_q <= tilt_est_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			tilt_est_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					diff_q     <= 17'(in_gyro) - 17'(gyro_offset_q);
					zero_vec_q <= (in_ax == 16'sd0) && (in_az == 16'sd0);
					if (in_ax[15]) begin
						cx_q <= 32'sd0 - ax_ext;
						cy_q <= 32'sd0 - az_ext;
						cz_q <= in_az[15] ? -tilt_est_pkg::HALF_TURN : tilt_est_pkg::HALF_TURN;
					end else begin
						cx_q <= ax_ext;
						cy_q <= az_ext;
						cz_q <= 32'sd0;
					end
				end
			end
			tilt_est_pkg::ST_RATE: begin
				rate_q <= diff_q[16] ? $signed(13'd0 - quot) : $signed(quot);
			end
			tilt_est_pkg::ST_PRED: begin
				pred_q <= angle_q + 32'(rate_x_period);
			end
			tilt_est_pkg::ST_CORDIC: begin
				if (!cy_q[31]) begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + atan_v;
				end else begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - atan_v;
				end
			end
			tilt_est_pkg::ST_ACC: begin
				acc_q <= zero_vec_q ? 32'sd0 : (z_biased >>> 8);
			end
			tilt_est_pkg::ST_QUAL: begin
				if (out_free) begin
					m_data_q <= {1'b0, used, bal_next, rate_q, angle_q};
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- bench/tb_tilt_estimator_with_balance_qualifier_top.sv -----
// Self-checking bench for the complementary-filter tilt estimator: drives update ticks and
// APB register writes, predicts the results of unpinned ticks with a cycle-free model of the estimator.
// Depends on tilt_est_pkg and tilt_estimator_with_balance_qualifier_top.
module tb_tilt_estimator_with_balance_qualifier_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CORDIC_ITERS  = tilt_est_pkg::CORDIC_STEPS_DEF;
	localparam int QUALIFY_LIMIT = tilt_est_pkg::QUALIFY_TICKS_DEF;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam int HOLD_CYCLES   = 400;
	localparam longint HALF_CIRCLE_Q8 = 46080177;

	// atan(2^-i) in 1/256 millidegree
	localparam longint ARCTAN_STEP [24] = '{
		11520044, 6800679, 3593292, 1824011, 915545, 458219, 229165, 114590,
		57296, 28648, 14324, 7162, 3581, 1790, 895, 448,
		224, 112, 56, 28, 14, 7, 3, 2
	};

	typedef struct packed {
		logic               accel_used;
		logic               balancing;
		logic signed [12:0] rate;
		logic signed [31:0] angle;
	} tilt_result_t;

	typedef struct packed {
		logic signed [15:0] gyro;
		logic signed [15:0] ax;
		logic signed [15:0] az;
		logic               pinned;
		tilt_result_t       res;
	} tick_row_t;

	typedef enum int {TK_QUIET, TK_DRIFT, TK_SPIN, TK_NOISE} tick_kind_t;

	// Opening rows carry the obvious results after reset; the rest go through the predictor.
	localparam tick_row_t DIRECTED_TICKS [25] = '{
		'{16'sd0,      16'sd0,      16'sd0,      1'b1, '{1'b1, 1'b0, 13'sd0, 32'sd0}},
		'{16'sh7FFF,   16'sd0,      16'sd0,      1'b1, '{1'b0, 1'b0, 13'sd1129, 32'sd11290}},
		'{16'sh8000,   16'sd0,      16'sd0,      1'b1, '{1'b0, 1'b0, -13'sd1129, 32'sd0}},
		'{16'sd0,      16'sd1000,   16'sd0,      1'b0, '0},
		'{16'sd28,     16'sh7FFF,   16'sd0,      1'b0, '0},
		'{-16'sd28,    16'sh7FFF,   16'sd1,      1'b0, '0},
		'{16'sd58,     16'sh8000,   16'sd0,      1'b0, '0},
		'{-16'sd58,    -16'sd100,   -16'sd1,     1'b0, '0},
		'{16'sd1421,   16'sd0,      16'sh7FFF,   1'b0, '0},
		'{16'sd1450,   16'sd0,      16'sh8000,   1'b0, '0},
		'{-16'sd1421,  16'sh7FFF,   16'sh7FFF,   1'b0, '0},
		'{-16'sd1450,  16'sh8000,   16'sh8000,   1'b0, '0},
		'{16'sd29,     16'sh8000,   16'sh7FFF,   1'b0, '0},
		'{-16'sd29,    16'sh7FFF,   16'sh8000,   1'b0, '0},
		'{16'sh7FFF,   16'sd0,      16'sd0,      1'b0, '0},
		'{16'sh7FFF,   16'sh5555,   16'shAAAA,   1'b0, '0},
		'{16'sh7FFF,   16'shAAAA,   16'sh5555,   1'b0, '0},
		'{16'sh7FFF,   16'sd100,    -16'sd100,   1'b0, '0},
		'{16'sh7FFF,   -16'sd1,     16'sd1,      1'b0, '0},
		'{16'sh7FFF,   16'sd1,      -16'sd1,     1'b0, '0},
		'{16'sh7FFF,   16'sh7FFF,   16'sh8000,   1'b0, '0},
		'{16'sh7FFF,   16'sh8000,   16'sh7FFF,   1'b0, '0},
		'{16'sh7FFF,   16'sd1,      16'sd0,      1'b0, '0},
		'{16'sh7FFF,   16'sd12345,  -16'sd12345, 1'b0, '0},
		'{16'sh8000,   16'sd0,      16'sd0,      1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;  // gyro_y[15:0], accel_x[31:16], accel_z[47:32]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;       // tilt_angle[31:0], tilt_rate[44:32], balancing[45],
	                                 // accel_used[46], zero[47]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic         tick_pinned = 1'b0;
	tilt_result_t tick_pinned_res = '0;

	// Estimator shadow: configuration and state
	logic signed [15:0] cfg_offset = 16'sd0;
	logic [7:0]         cfg_period = 8'd10;
	logic [17:0]        cfg_start = 18'd20000;
	logic [17:0]        cfg_stop = 18'd45000;
	logic [31:0]        est_angle = '0;
	logic               est_balance = 1'b0;
	int                 est_qcount = 0;

	tilt_result_t pending_tilt [$];
	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int holds_asked = 0;

	tilt_estimator_with_balance_qualifier_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// atan2(ys, xs) in millidegrees by vectoring rotation, truncated toward zero
	function automatic logic signed [31:0] accel_mdeg(input logic signed [15:0] ys,
	                                                  input logic signed [15:0] xs);
		longint vx, vy, va, nx;
		vx = longint'(xs) * 4096;
		vy = longint'(ys) * 4096;
		va = 0;
		if (xs == 0 && ys == 0)
			return 32'sd0;
		if (xs < 0) begin
			va = (ys >= 0) ? HALF_CIRCLE_Q8 : -HALF_CIRCLE_Q8;
			vx = -vx;
			vy = -vy;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			if (vy >= 0) begin
				nx = vx + (vy >>> i);
				vy = vy - (vx >>> i);
				va += ARCTAN_STEP[i];
			end else begin
				nx = vx - (vy >>> i);
				vy = vy + (vx >>> i);
				va -= ARCTAN_STEP[i];
			end
			vx = nx;
		end
		return 32'(va / 256);
	endfunction

	function automatic tilt_result_t advance_tilt(input logic signed [15:0] gy,
	                                              input logic signed [15:0] ax,
	                                              input logic signed [15:0] az);
		int                 rate;
		logic signed [31:0] acc;
		logic [31:0]        pred, blend, mag;
		logic               used, hit;
		tilt_result_t       r;
		rate = (int'(gy) - int'(cfg_offset)) / 29;
		acc = '0;
		pred = est_angle + 32'(rate * int'(cfg_period));
		used = (rate > -50) && (rate < 50);
		if (used) begin
			acc = accel_mdeg(az, ax);
			blend = pred * 32'd252 + 32'(acc) * 32'd4;
			est_angle = 32'($signed(blend) >>> 8);
		end else begin
			est_angle = pred;
		end
		// snap to the accelerometer when at rest and not balancing
		if (!est_balance && rate > -2 && rate < 2)
			est_angle = acc;
		mag = est_angle[31] ? -est_angle : est_angle;
		hit = est_balance ? (mag > 32'(cfg_stop)) : (mag < 32'(cfg_start));
		if (hit) begin
			est_qcount++;
			if (est_qcount > QUALIFY_LIMIT) begin
				est_balance = ~est_balance;
				est_qcount = 0;
			end
		end else begin
			est_qcount = 0;
		end
		r.angle = est_angle;
		r.rate = 13'(rate);
		r.balancing = est_balance;
		r.accel_used = used;
		return r;
	endfunction

	task automatic report_field(input string field, input logic signed [63:0] want,
	                            input logic signed [63:0] seen);
		if (seen !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, seen);
			fail_count++;
		end
	endtask

	// Register writes, result checks and prediction, all on the rising edge
	always @(posedge clk) begin
		tilt_result_t got, want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (tilt_est_pkg::reg_idx_t'(paddr[3:2]))
					tilt_est_pkg::REG_GYRO_OFFSET:     cfg_offset = pwdata[15:0];
					tilt_est_pkg::REG_UPDATE_PERIOD:   cfg_period = pwdata[7:0];
					tilt_est_pkg::REG_START_THRESHOLD: cfg_start = pwdata[17:0];
					tilt_est_pkg::REG_STOP_THRESHOLD:  cfg_stop = pwdata[17:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[46:0];
				if (pending_tilt.size() == 0) begin
					$error("tilt result with no tick outstanding: tdata=%h", m_axis_tdata);
					fail_count++;
				end else begin
					want = pending_tilt.pop_front();
					report_field("tilt_angle", want.angle, got.angle);
					report_field("tilt_rate", want.rate, got.rate);
					report_field("balancing", want.balancing, got.balancing);
					report_field("accel_used", want.accel_used, got.accel_used);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = advance_tilt(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32]);
				if (tick_pinned)
					want = tick_pinned_res;
				pending_tilt.push_back(want);
			end
		end
	end

	// Receiver: random stall modes, plus a long hold-off on request
	always @(negedge clk) begin
		static int hold_left = 0;
		static int holds_served = 0;
		static int mode_left = 0;
		static int rx_mode = 0;
		static int rx_tick = 0;
		rx_tick++;
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			case (rx_mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
				2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (rx_tick % 3 == 0);
			endcase
		end
	end

	task automatic write_reg(input tilt_est_pkg::reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Upper bits of each write are junk; the registers keep only their own width.
	task automatic set_config(input int offset, input int period, input int start_th,
	                          input int stop_th);
		write_reg(tilt_est_pkg::REG_GYRO_OFFSET, {16'($urandom), 16'(offset)});
		write_reg(tilt_est_pkg::REG_UPDATE_PERIOD, {24'($urandom), 8'(period)});
		write_reg(tilt_est_pkg::REG_START_THRESHOLD, {14'($urandom), 18'(start_th)});
		write_reg(tilt_est_pkg::REG_STOP_THRESHOLD, {14'($urandom), 18'(stop_th)});
	endtask

	task automatic send_tick(input tick_row_t row);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (gap != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {row.az, row.ax, row.gyro};
		tick_pinned <= row.pinned;
		tick_pinned_res <= row.res;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering and hold until every result is back
	task automatic drain_ticks();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_tilt.size() != 0) @(negedge clk);
	endtask

	function automatic tick_row_t make_tick(input tick_kind_t kind);
		int diff, g, sgn, lim;
		tick_row_t t;
		sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
		case (kind)
			TK_QUIET: diff = int'($urandom_range(0, 86)) - 43;
			TK_DRIFT: diff = sgn * (int'($urandom_range(2, 49)) * 29 + int'($urandom_range(0, 28)));
			TK_SPIN:  diff = sgn * (int'($urandom_range(50, 2259)) * 29
			                       + int'($urandom_range(0, 28)));
			default:  diff = 0;
		endcase
		g = int'(cfg_offset) + diff;
		if (g > 32767)
			g = 32767;
		if (g < -32768)
			g = -32768;
		t.gyro = (kind == TK_NOISE) ? 16'($urandom) : 16'(g);
		lim = $urandom_range(1000, 32767);
		case ($urandom_range(0, 15))
			0: begin
				t.ax = '0;
				t.az = '0;
			end
			1, 2, 3, 4, 5, 6, 7: begin
				// near-level vector: small accelerometer angle
				t.ax = 16'(lim);
				t.az = 16'(int'($urandom_range(0, lim / 2)) - lim / 4);
			end
			default: begin
				t.ax = 16'($urandom);
				t.az = 16'($urandom);
			end
		endcase
		t.pinned = 1'b0;
		t.res = '0;
		return t;
	endfunction

	// Runs of one kind of tick, so the qualifier sees streaks
	task automatic run_random(input int count);
		int left, pick, run;
		tick_kind_t kind;
		left = count;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			kind = (pick < 45) ? TK_QUIET : (pick < 65) ? TK_DRIFT :
			       (pick < 90) ? TK_SPIN : TK_NOISE;
			run = $urandom_range(1, 12);
			for (int j = 0; j < run && left > 0; j++) begin
				send_tick(make_tick(kind));
				left--;
			end
		end
	endtask

	initial begin
		tick_row_t spin;
		int start_th;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_TICKS[i])
			send_tick(DIRECTED_TICKS[i]);
		drain_ticks();

		// Full-rate spin to a huge estimate, then blend where 252 * angle wraps
		set_config(-32768, 255, 180000, 0);
		for (int i = 0; i < 300; i++) begin
			spin.gyro = 16'sh7FFF;
			spin.ax = 16'($urandom);
			spin.az = 16'($urandom);
			spin.pinned = 1'b0;
			spin.res = '0;
			send_tick(spin);
		end
		for (int i = 0; i < 20; i++)
			send_tick(make_tick(TK_DRIFT));
		drain_ticks();

		set_config(32767, 0, 262143, 262143);
		run_random(120);
		drain_ticks();

		set_config(int'($urandom_range(0, 600)) - 300, 1, 0, 180000);
		holds_asked++;
		run_random(120);
		drain_ticks();

		set_config(0, 10, 20000, 45000);
		run_random(130);
		drain_ticks();

		repeat (4) begin
			start_th = $urandom_range(0, 180000);
			set_config(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
			                                       : int'($urandom_range(0, 600)) - 300,
			           $urandom_range(0, 255), start_th, $urandom_range(start_th, 180000));
			run_random(50);
			drain_ticks();
			run_random(50);
			drain_ticks();
		end

		repeat (4 * (CORDIC_ITERS + 6)) @(negedge clk);
		if (pending_tilt.size() != 0) begin
			$error("%0d tilt results never arrived", pending_tilt.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/tilt_est_pkg.sv
rtl/tilt_estimator_with_balance_qualifier_top.sv
bench/tb_tilt_estimator_with_balance_qualifier_top.sv
